>>> rtl/core/pisr_pkg.sv
// ----------------------------------------------------------------------------
// pisr_pkg
// Shared types and constants for the PI speed regulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pisr_pkg;

   localparam int SPEED_W    = 16;
   localparam int GAIN_W     = 15;
   localparam int LIMIT_W    = 20;
   localparam int INTEG_W    = 21;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam int PTERM_W = 32;
   localparam int ITERM_W = 37;
   localparam int SUM_W   = 38;
   localparam int MAG_W   = 22;
   localparam int RECIP_W = 23;
   localparam int RECIP_SHIFT = 29;
   localparam int QMAG_W  = 16;

   typedef logic signed [SPEED_W-1:0] speed_type;
   typedef logic [GAIN_W-1:0]         gain_type;
   typedef logic [LIMIT_W-1:0]        limit_type;
   typedef logic signed [INTEG_W-1:0] integ_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP    = 2'd0,
      CSR_KI    = 2'd1,
      CSR_LIMIT = 2'd2
   } csr_index_type;

   localparam gain_type  KP_RESET    = 15'd250;
   localparam gain_type  KI_RESET    = 15'd4;
   localparam limit_type LIMIT_RESET = 20'd50000;

   // |sum| at or above this value always saturates (100 * 32769)
   localparam logic [MAG_W-1:0]   MAG_CLAMP = 22'd3276900;
   // ceil(2^29 / 100): exact quotient by 100 for magnitudes below 2^22
   localparam logic [RECIP_W-1:0] RECIP_100 = 23'd5368710;

   localparam logic [QMAG_W-1:0] QMAG_POS_MAX = 16'd32767;
   localparam logic [QMAG_W-1:0] QMAG_NEG_MAX = 16'd32768;

endpackage

`default_nettype wire

>>> rtl/core/pi_speed_regulator_unit.sv
// ----------------------------------------------------------------------------
// pi_speed_regulator_unit
// PI speed regulator with clamped integral and saturated drive output.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one control tick (target, measured speed, hold flag);
//   a transaction is taken when req_valid is high and req_stall is low.
//   rsp_* returns one drive value per tick, in order, taken when rsp_valid
//   is high and rsp_stall is low.
//   csr_* writes kp, ki and integral_limit; csr_ready is always high.
//   Write registers only while the pipeline is empty.
// Pipeline: six registers (input, integral update, products, sum/clamp,
//   reciprocal divide, saturate/output) lie between an input transaction
//   and rsp_valid.
// Throughput: one tick per cycle while rsp_stall does not hold the
//   pipeline; the integral update closes its loop in a single stage.
// Reset: gains and limit return to 250, 4 and 50000, the integral to zero,
//   all stages empty.
// Stall: a stalled result holds; earlier stages keep filling into empty
//   slots, and req_stall rises only once every stage holds a tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pi_speed_regulator_unit (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire pisr_pkg::speed_type          req_target_speed,
   input  wire pisr_pkg::speed_type          req_measured_speed,
   input  wire                               req_hold_integral,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output pisr_pkg::speed_type               rsp_drive,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire [pisr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [pisr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pisr_pkg::*;

   gain_type  kp_ff, ki_ff;
   limit_type limit_ff;
   integ_type integral_ff, integral_in;

   logic      v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic      rdy0, rdy1, rdy2, rdy3, rdy4, rdy5;

   speed_type s0_target_ff, s0_measured_ff;
   logic      s0_hold_ff;

   speed_type s1_error_ff, s1_error_in;
   integ_type s1_acc_ff;

   logic signed [PTERM_W-1:0] s2_pterm_ff, s2_pterm_in;
   logic signed [ITERM_W-1:0] s2_iterm_ff, s2_iterm_in;

   logic [MAG_W-1:0] s3_mag_ff, s3_mag_in;
   logic             s3_neg_ff, s3_neg_in;

   logic [QMAG_W-1:0] s4_qmag_ff, s4_qmag_in;
   logic              s4_neg_ff;

   speed_type rsp_drive_ff, rsp_drive_in;

   logic signed [INTEG_W:0]  acc_wide;
   logic signed [INTEG_W:0]  lim_pos;
   logic signed [SUM_W-1:0]  sum;
   logic [SUM_W-1:0]         sum_mag;
   logic [MAG_W+RECIP_W-1:0] recip_prod;
   logic [QMAG_W:0]          qneg;

   // transaction flow: a stage moves when the next one is empty or moving
   assign rdy5 = !v5_ff || !rsp_stall;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign rdy0 = !v0_ff || rdy1;

   assign req_stall = !rdy0;
   assign rsp_valid = v5_ff;
   assign rsp_drive = rsp_drive_ff;
   assign csr_ready = 1'b1;

   // integral update
   always_comb begin
      s1_error_in = s0_target_ff - s0_measured_ff;
      lim_pos     = $signed({2'b00, limit_ff});
      acc_wide    = (INTEG_W+1)'(integral_ff);
      if (!s0_hold_ff) begin
         acc_wide = acc_wide + (INTEG_W+1)'(s1_error_in);
      end
      if (acc_wide > lim_pos) begin
         integral_in = INTEG_W'(lim_pos);
      end else if (acc_wide < -lim_pos) begin
         integral_in = INTEG_W'(-lim_pos);
      end else begin
         integral_in = INTEG_W'(acc_wide);
      end
   end

   // products
   always_comb begin
      s2_pterm_in = PTERM_W'($signed({1'b0, kp_ff})) * PTERM_W'(s1_error_ff);
      s2_iterm_in = ITERM_W'($signed({1'b0, ki_ff})) * ITERM_W'(s1_acc_ff);
   end

   // sum, magnitude, early clamp
   always_comb begin
      sum       = SUM_W'(s2_pterm_ff) + SUM_W'(s2_iterm_ff);
      s3_neg_in = sum[SUM_W-1];
      sum_mag   = s3_neg_in ? SUM_W'(-sum) : SUM_W'(sum);
      if (sum_mag >= SUM_W'(MAG_CLAMP)) begin
         s3_mag_in = MAG_CLAMP;
      end else begin
         s3_mag_in = sum_mag[MAG_W-1:0];
      end
   end

   // divide by 100
   always_comb begin
      recip_prod = (MAG_W+RECIP_W)'(s3_mag_ff) * (MAG_W+RECIP_W)'(RECIP_100);
      s4_qmag_in = recip_prod[RECIP_SHIFT +: QMAG_W];
   end

   // sign and saturate
   always_comb begin
      qneg = (QMAG_W+1)'(0) - {1'b0, s4_qmag_ff};
      if (s4_neg_ff) begin
         if (s4_qmag_ff > QMAG_NEG_MAX) begin
            rsp_drive_in = speed_type'(QMAG_NEG_MAX);
         end else begin
            rsp_drive_in = qneg[QMAG_W-1:0];
         end
      end else begin
         if (s4_qmag_ff > QMAG_POS_MAX) begin
            rsp_drive_in = speed_type'(QMAG_POS_MAX);
         end else begin
            rsp_drive_in = s4_qmag_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff       <= KP_RESET;
         ki_ff       <= KI_RESET;
         limit_ff    <= LIMIT_RESET;
         integral_ff <= '0;
         v0_ff       <= 1'b0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         v4_ff       <= 1'b0;
         v5_ff       <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_KP:    kp_ff    <= csr_wdata[GAIN_W-1:0];
               CSR_KI:    ki_ff    <= csr_wdata[GAIN_W-1:0];
               CSR_LIMIT: limit_ff <= csr_wdata[LIMIT_W-1:0];
               default:   ;
            endcase
         end
         if (v0_ff && rdy1) begin
            integral_ff <= integral_in;
         end
         if (rdy0) v0_ff <= req_valid;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy0) begin
         s0_target_ff   <= req_target_speed;
         s0_measured_ff <= req_measured_speed;
         s0_hold_ff     <= req_hold_integral;
      end
      if (rdy1) begin
         s1_error_ff <= s1_error_in;
         s1_acc_ff   <= integral_in;
      end
      if (rdy2) begin
         s2_pterm_ff <= s2_pterm_in;
         s2_iterm_ff <= s2_iterm_in;
      end
      if (rdy3) begin
         s3_mag_ff <= s3_mag_in;
         s3_neg_ff <= s3_neg_in;
      end
      if (rdy4) begin
         s4_qmag_ff <= s4_qmag_in;
         s4_neg_ff  <= s3_neg_ff;
      end
      if (rdy5) begin
         rsp_drive_ff <= rsp_drive_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/pisr_checker.sv
// ----------------------------------------------------------------------------
// pisr_checker
// Port-level checks for the PI speed regulator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pisr_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_stall,
   input wire                                rsp_valid,
   input wire                                rsp_stall,
   input wire [pisr_pkg::SPEED_W-1:0]        rsp_drive
);
   import pisr_pkg::*;

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_drive_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_drive))
      else $error("rsp_drive changed while stalled");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall raised without a stalled result");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

bind pi_speed_regulator_unit pisr_checker u_pisr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_drive (rsp_drive)
);

`default_nettype wire
